/* design/assert_macros.svh */
// Assertion macros shared by the checker file of the frame allocator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define CFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("allocator check failed");

// Clocked assertion that also holds during reset.
`define CFA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("allocator check failed");

`endif

/* design/cfa_pkg.sv */
// Package for the contiguous frame allocator: codes, types, widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cfa_pkg;

  // Frame state codes
  typedef enum logic [1:0] {
    FS_FREE  = 2'd0,
    FS_ALLOC = 2'd1,
    FS_HEAD  = 2'd2,
    FS_RSVD  = 2'd3
  } frame_state_t;

  // Request codes
  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_MARK    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // Result status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_NOFIT   = 3'd1;
  localparam logic [2:0] STAT_RANGE   = 3'd2;
  localparam logic [2:0] STAT_NOTHEAD = 3'd3;
  localparam logic [2:0] STAT_ZERO    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_BASE_FRAME  = 2'd0;
  localparam logic [1:0] REG_POOL_FRAMES = 2'd1;

  localparam int FNW = 20;  // frame number width
  localparam int CNW = 11;  // count width
  localparam logic [CNW-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } ctrl_state_t;

  // Shift control handed to every cell of the ring
  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* design/cfa_cell.sv */
// One frame cell of the state ring: holds a 2-bit frame state.
// Depends on cfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfa_cell
  import cfa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cell_ctrl_t   ctrl,
  input  wire frame_state_t d_in,
  output frame_state_t      q
);

  frame_state_t q_r;

  // Take the neighbour's state on every shift; reset to free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= FS_FREE;
    end else if (ctrl.shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

/* design/contiguous_frame_allocator_core.sv */
// Contiguous frame allocator: ring of frame cells rotated past one controller.
// Each request runs through check and done; release and mark add a write rotation,
// allocate adds a search rotation and, with a fit, a write rotation; a request
// refused by the range or count check goes straight to done. One request at a time.
// Result strobe out_valid lasts one cycle; the receiver cannot stall.
// Reset (rst_n, synchronous): all frames free, base_frame 0, pool_frames 1024.
`timescale 1ns / 1ps
`default_nettype none
module contiguous_frame_allocator_core
  import cfa_pkg::*;
#(
  parameter int FRAMES = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_action,
  input  wire logic [FNW-1:0]   in_frame_number,
  input  wire logic [CNW-1:0]   in_frame_count,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [FNW-1:0]        out_first_frame,
  output logic [CNW-1:0]        out_frames_changed,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [FNW-1:0]   cfg_data
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW = $clog2(FRAMES + 1);
  localparam int PW = (NW > CNW) ? NW : CNW;
  localparam int EW = PW + 1;
  localparam int AW = FNW + 1;
  localparam logic [IW-1:0] P_LAST = IW'(FRAMES - 1);

  ctrl_state_t state_r, state_nxt;

  logic [FNW-1:0] base_r;
  logic [CNW-1:0] pool_r;
  action_t        act_r;
  logic [FNW-1:0] fn_r;
  logic [CNW-1:0] cnt_r;

  logic [IW-1:0]  p_r, p_nxt;
  logic [PW-1:0]  n_r, n_nxt;
  logic [PW-1:0]  idx_r, idx_nxt;
  logic [PW-1:0]  start_r, start_nxt;
  logic [CNW-1:0] run_r, run_nxt;
  logic           found_r, found_nxt;
  logic           is_rel_r, is_rel_nxt;
  logic           rel_act_r, rel_act_nxt;
  logic           nothead_r, nothead_nxt;
  logic [CNW-1:0] chg_r, chg_nxt;
  logic [2:0]     status_r, status_nxt;
  logic [FNW-1:0] first_r, first_nxt;

  frame_state_t   cell_q [FRAMES];
  frame_state_t   new_v;
  cell_ctrl_t     cell_ctrl;

  logic           accept;
  logic [PW-1:0]  p_ext;
  logic           in_pool;
  logic           in_rng;
  logic [EW-1:0]  end_pos;
  logic [AW-1:0]  pool_end;
  logic [AW-1:0]  mark_end;
  logic [PW-1:0]  pool_ext;
  logic [FNW-1:0] fn_off;

  assign accept = start && !busy;

  // Ring of cells: cell 0 is seen by the controller, its update enters at the tail
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    frame_state_t d;
    if (i == FRAMES - 1) begin : g_tail
      assign d = new_v;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    cfa_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (cell_ctrl),
      .d_in  (d),
      .q     (cell_q[i])
    );
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      pool_r <= CNW'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_FRAME:  base_r <= cfg_data;
        REG_POOL_FRAMES: pool_r <= cfg_data[CNW-1:0];
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= action_t'(in_action);
      fn_r  <= in_frame_number;
      cnt_r <= in_frame_count;
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    n_r       <= n_nxt;
    idx_r     <= idx_nxt;
    start_r   <= start_nxt;
    run_r     <= run_nxt;
    found_r   <= found_nxt;
    is_rel_r  <= is_rel_nxt;
    rel_act_r <= rel_act_nxt;
    nothead_r <= nothead_nxt;
    chg_r     <= chg_nxt;
    status_r  <= status_nxt;
    first_r   <= first_nxt;
  end

  // Shared address arithmetic
  assign pool_ext = PW'(pool_r);
  assign p_ext    = PW'(p_r);
  assign in_pool  = p_ext < n_r;
  assign end_pos  = EW'(idx_r) + EW'(cnt_r);
  assign in_rng   = (p_ext >= idx_r) && (EW'(p_ext) < end_pos);
  assign pool_end = AW'(base_r) + AW'(n_r);
  assign mark_end = AW'(fn_r) + AW'(cnt_r);
  assign fn_off   = fn_r - base_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ST_DONE;
        case (act_r)
          ACT_ALLOC: begin
            if (cnt_r != '0 && PW'(cnt_r) <= n_r) state_nxt = ST_SCAN;
          end
          ACT_RELEASE: begin
            if (fn_r >= base_r && AW'(fn_r) < pool_end) state_nxt = ST_WRITE;
          end
          ACT_MARK: begin
            if (cnt_r != '0 && fn_r >= base_r && mark_end <= pool_end) begin
              state_nxt = ST_WRITE;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (p_r == P_LAST) state_nxt = found_nxt ? ST_WRITE : ST_DONE;
      end
      ST_WRITE: begin
        if (p_r == P_LAST) state_nxt = ST_DONE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath next values and the value written back into the ring
  always_comb begin
    p_nxt       = p_r;
    n_nxt       = n_r;
    idx_nxt     = idx_r;
    start_nxt   = start_r;
    run_nxt     = run_r;
    found_nxt   = found_r;
    is_rel_nxt  = is_rel_r;
    rel_act_nxt = rel_act_r;
    nothead_nxt = nothead_r;
    chg_nxt     = chg_r;
    status_nxt  = status_r;
    first_nxt   = first_r;
    new_v       = cell_q[0];
    case (state_r)
      ST_IDLE: begin
        n_nxt = (pool_ext > PW'(FRAMES)) ? PW'(FRAMES) : pool_ext;
      end
      ST_CHECK: begin
        p_nxt       = '0;
        run_nxt     = '0;
        found_nxt   = 1'b0;
        rel_act_nxt = 1'b0;
        nothead_nxt = 1'b0;
        chg_nxt     = '0;
        first_nxt   = '0;
        idx_nxt     = fn_off[PW-1:0];
        is_rel_nxt  = (act_r == ACT_RELEASE);
        status_nxt  = STAT_RANGE;
        case (act_r)
          ACT_ALLOC: begin
            if (cnt_r == '0)              status_nxt = STAT_ZERO;
            else if (PW'(cnt_r) > n_r)    status_nxt = STAT_NOFIT;
            else                          status_nxt = STAT_OK;
          end
          ACT_RELEASE: begin
            if (fn_r >= base_r && AW'(fn_r) < pool_end) status_nxt = STAT_OK;
          end
          ACT_MARK: begin
            if (cnt_r == '0) status_nxt = STAT_ZERO;
            else if (fn_r >= base_r && mark_end <= pool_end) status_nxt = STAT_OK;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        // First-fit search: count the free run passing the controller
        p_nxt = p_r + 1'b1;
        if (!found_r && in_pool) begin
          if (cell_q[0] == FS_FREE) begin
            if (run_r == '0) start_nxt = p_ext;
            run_nxt = run_r + 1'b1;
            if (run_nxt == cnt_r) found_nxt = 1'b1;
          end else begin
            run_nxt = '0;
          end
        end
        if (p_r == P_LAST) begin
          if (found_nxt) begin
            idx_nxt   = start_nxt;
            first_nxt = base_r + FNW'(start_nxt);
            p_nxt     = '0;
          end else begin
            status_nxt = STAT_NOFIT;
          end
        end
      end
      ST_WRITE: begin
        p_nxt = p_r + 1'b1;
        if (is_rel_r) begin
          // Release: head first, then the followers until a non-follower
          if (p_ext == idx_r) begin
            if (cell_q[0] != FS_HEAD) begin
              nothead_nxt = 1'b1;
            end else begin
              new_v       = FS_FREE;
              chg_nxt     = CNW'(1);
              rel_act_nxt = 1'b1;
            end
          end else if (rel_act_r && in_pool && p_ext > idx_r) begin
            if (cell_q[0] == FS_ALLOC) begin
              new_v   = FS_FREE;
              chg_nxt = (chg_r == CNT_MAX) ? chg_r : chg_r + 1'b1;
            end else begin
              rel_act_nxt = 1'b0;
            end
          end
        end else if (in_rng) begin
          // Mark or allocate: head then followers over the range
          new_v = (p_ext == idx_r) ? FS_HEAD : FS_ALLOC;
          if (cell_q[0] != new_v) begin
            chg_nxt = (chg_r == CNT_MAX) ? chg_r : chg_r + 1'b1;
          end
        end
        if (p_r == P_LAST && nothead_nxt) status_nxt = STAT_NOTHEAD;
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    busy               = (state_r != ST_IDLE);
    cfg_ready          = (state_r == ST_IDLE);
    cell_ctrl.shift    = (state_r == ST_SCAN) || (state_r == ST_WRITE);
    out_valid          = (state_r == ST_DONE);
    out_status         = status_r;
    out_first_frame    = (status_r == STAT_OK) ? first_r : '0;
    out_frames_changed = (status_r == STAT_OK) ? chg_r : '0;
  end

endmodule
`default_nettype wire

/* design/cfa_checker.sv */
// Port-level checker for the frame allocator, bound to the top level.
// Depends on cfa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cfa_checker
  import cfa_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            out_valid,
  input wire logic [2:0]      out_status,
  input wire logic [FNW-1:0]  out_first_frame,
  input wire logic [CNW-1:0]  out_frames_changed,
  input wire logic            cfg_ready
);

  // An accepted request makes the block busy
  `CFA_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
  // A result strobe lasts one cycle and frees the block
  `CFA_ASSERT(a_one_result, clk, rst_n, out_valid |=> (!out_valid && !busy))
  // A result only comes out of a request under way
  `CFA_ASSERT(a_result_busy, clk, rst_n, out_valid |-> busy)
  // Failed requests report nothing changed
  `CFA_ASSERT(a_fail_quiet, clk, rst_n,
    (out_valid && out_status != STAT_OK) |-> (out_first_frame == '0 && out_frames_changed == '0))
  // Configuration is only taken while idle
  `CFA_ASSERT(a_cfg_idle, clk, rst_n, cfg_ready |-> !busy)

endmodule

bind contiguous_frame_allocator_core cfa_checker u_cfa_checker (.*);
`default_nettype wire

/* test/contiguous_frame_allocator_checker.sv */
// Checker for the contiguous frame allocator: watches request, result and
// register transfers, predicts each result and compares it. Depends on cfa_pkg.
`timescale 1ns / 1ps
module contiguous_frame_allocator_checker
  import cfa_pkg::*;
#(
  parameter int FRAMES = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  logic [1:0]     in_action,
  input  logic [FNW-1:0] in_frame_number,
  input  logic [CNW-1:0] in_frame_count,
  input  logic           out_valid,
  input  logic [2:0]     out_status,
  input  logic [FNW-1:0] out_first_frame,
  input  logic [CNW-1:0] out_frames_changed,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [FNW-1:0] cfg_data,
  output int             fail_count,
  output int             outstanding
);

  typedef struct packed {
    logic [2:0]     status;
    logic [FNW-1:0] first_frame;
    logic [CNW-1:0] frames_changed;
  } reply_t;

  frame_state_t   frame_map [FRAMES];
  logic [FNW-1:0] base_frame;
  logic [CNW-1:0] pool_frames;
  reply_t         expected_replies [$];

  function automatic logic [CNW-1:0] sat_count(int unsigned v);
    return (v > int'(CNT_MAX)) ? CNT_MAX : CNW'(v);
  endfunction

  // Apply one request to the frame map and work out its result
  function automatic reply_t serve_request(logic [1:0] act, logic [FNW-1:0] fn,
                                           logic [CNW-1:0] cnt);
    reply_t        r;
    int unsigned   n, run, first, changed, off;
    longint unsigned lim;
    bit            found;
    frame_state_t  want;
    r = '0;
    n = (int'(pool_frames) > FRAMES) ? FRAMES : pool_frames;
    lim = longint'(base_frame) + n;
    case (action_t'(act))
      ACT_ALLOC: begin
        if (cnt == 0) r.status = STAT_ZERO;
        else if (cnt > n) r.status = STAT_NOFIT;
        else begin
          run = 0; first = 0; found = 0;
          for (int unsigned i = 0; i < n && !found; i++) begin
            if (frame_map[i] == FS_FREE) begin
              if (run == 0) first = i;
              run++;
              if (run == cnt) found = 1;
            end else begin
              run = 0;
            end
          end
          if (!found) r.status = STAT_NOFIT;
          else begin
            frame_map[first] = FS_HEAD;
            for (int unsigned i = 1; i < cnt; i++) frame_map[first + i] = FS_ALLOC;
            r.status = STAT_OK;
            r.first_frame = FNW'(base_frame + first);
            r.frames_changed = sat_count(cnt);
          end
        end
      end
      ACT_RELEASE: begin
        if (fn < base_frame || longint'(fn) >= lim) r.status = STAT_RANGE;
        else begin
          off = fn - base_frame;
          if (frame_map[off] != FS_HEAD) r.status = STAT_NOTHEAD;
          else begin
            frame_map[off] = FS_FREE;
            changed = 1;
            for (int unsigned i = off + 1; i < n; i++) begin
              if (frame_map[i] != FS_ALLOC) break;
              frame_map[i] = FS_FREE;
              changed++;
            end
            r.status = STAT_OK;
            r.frames_changed = sat_count(changed);
          end
        end
      end
      ACT_MARK: begin
        if (cnt == 0) r.status = STAT_ZERO;
        else if (fn < base_frame || longint'(fn) + cnt > lim) r.status = STAT_RANGE;
        else begin
          off = fn - base_frame;
          changed = 0;
          for (int unsigned i = 0; i < cnt; i++) begin
            want = (i == 0) ? FS_HEAD : FS_ALLOC;
            if (frame_map[off + i] != want) changed++;
            frame_map[off + i] = want;
          end
          r.status = STAT_OK;
          r.frames_changed = sat_count(changed);
        end
      end
      default: r.status = STAT_RANGE;
    endcase
    return r;
  endfunction

  assign outstanding = expected_replies.size();

  // Sampled at the edge, before the block's own updates land
  always @(posedge clk) begin
    reply_t e;
    if (!rst_n) begin
      foreach (frame_map[i]) frame_map[i] = FS_FREE;
      base_frame  = '0;
      pool_frames = 11'd1024;
      expected_replies.delete();
      fail_count  = 0;
    end else begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = expected_replies.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            fail_count++;
          end
          if (out_first_frame !== e.first_frame) begin
            $error("first_frame: expected %0h, got %0h", e.first_frame, out_first_frame);
            fail_count++;
          end
          if (out_frames_changed !== e.frames_changed) begin
            $error("frames_changed: expected %0d, got %0d",
                   e.frames_changed, out_frames_changed);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BASE_FRAME) base_frame = cfg_data;
        else if (cfg_index == REG_POOL_FRAMES) pool_frames = cfg_data[CNW-1:0];
      end
      if (start && !busy)
        expected_replies.push_back(serve_request(in_action, in_frame_number,
                                                 in_frame_count));
    end
  end

endmodule

/* test/contiguous_frame_allocator_core_tb.sv */
// Testbench top for the contiguous frame allocator: clock, reset, register
// phases and request stimulus. Depends on cfa_pkg and the checker module.
`timescale 1ns / 1ps
module contiguous_frame_allocator_core_tb;
  import cfa_pkg::*;

  localparam int FRAMES = 1024;
  localparam int CYCLE_LIMIT = 20_000_000;

  logic           clk, rst_n, start, busy;
  logic [1:0]     in_action;
  logic [FNW-1:0] in_frame_number;
  logic [CNW-1:0] in_frame_count;
  logic           out_valid;
  logic [2:0]     out_status;
  logic [FNW-1:0] out_first_frame;
  logic [CNW-1:0] out_frames_changed;
  logic           cfg_valid, cfg_ready;
  logic [1:0]     cfg_index;
  logic [FNW-1:0] cfg_data;
  int             fail_count, outstanding, cycles;

  // Stimulus-side view of the pool and of live heads
  logic [FNW-1:0] cur_base;
  int unsigned    cur_pool;
  logic [FNW-1:0] live_heads [$];
  action_t        last_action;
  logic [FNW-1:0] last_fn;
  bit             quiet;

  contiguous_frame_allocator_core #(.FRAMES(FRAMES)) u_dut (.*);

  contiguous_frame_allocator_checker #(.FRAMES(FRAMES)) u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("contiguous_frame_allocator_core: mismatch");
      $finish;
    end
  end

  // Remember heads created, so releases mostly hit real runs; the request
  // in flight is the one taken at the last accepting edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_status == STAT_OK) begin
      if (last_action == ACT_ALLOC) live_heads.push_back(out_first_frame);
      else if (last_action == ACT_MARK) live_heads.push_back(last_fn);
    end
    if (rst_n && start && !busy) begin
      last_action = action_t'(in_action);
      last_fn     = in_frame_number;
    end
  end

  task automatic gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) gap($urandom_range(1, 10));
  endtask

  // One request transfer; start stays high for a following request
  task automatic send(action_t act, logic [FNW-1:0] fn, logic [CNW-1:0] cnt);
    maybe_gap();
    start           <= 1'b1;
    in_action       <= act;
    in_frame_number <= fn;
    in_frame_count  <= cnt;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    gap(1);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [FNW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pool(logic [FNW-1:0] b, logic [CNW-1:0] p);
    drain();
    write_reg(REG_BASE_FRAME, b);
    write_reg(REG_POOL_FRAMES, FNW'(p));
    cur_base = b;
    cur_pool = (p > FRAMES) ? FRAMES : p;
    live_heads.delete();
  endtask

  function automatic logic [FNW-1:0] pool_frame();
    return FNW'(cur_base + $urandom_range(0, cur_pool));
  endfunction

  task automatic random_request();
    int unsigned    r, k;
    logic [FNW-1:0] fn;
    r = $urandom_range(0, 99);
    if (r < 38) begin
      send(ACT_ALLOC, '0, ($urandom_range(0, 9) == 0) ? CNW'($urandom_range(0, 1024))
                                                      : CNW'($urandom_range(1, 8)));
    end else if (r < 68) begin
      if (live_heads.size() != 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, live_heads.size() - 1);
        fn = live_heads[k];
        live_heads.delete(k);
      end else begin
        fn = ($urandom_range(0, 4) == 0) ? FNW'($urandom) : pool_frame();
      end
      send(ACT_RELEASE, fn, CNW'($urandom));
    end else if (r < 90) begin
      if ($urandom_range(0, 9) == 0)
        send(ACT_MARK, cur_base, CNW'(cur_pool));
      else
        send(ACT_MARK, ($urandom_range(0, 6) == 0) ? FNW'($urandom) : pool_frame(),
             CNW'($urandom_range(0, 8)));
    end else if (r < 97) begin
      send(ACT_ALLOC, FNW'($urandom), CNW'($urandom_range(0, 1024)));
    end else begin
      send(ACT_NONE, FNW'($urandom), CNW'($urandom));
    end
  endtask

  initial begin
    rst_n = 0; start = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_action = ACT_ALLOC; in_frame_number = '0; in_frame_count = '0;
    cycles = 0; quiet = 0; cur_base = '0; cur_pool = FRAMES;
    last_action = ACT_NONE; last_fn = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, each action, each error path
    set_pool(20'd0, 11'd1024);
    send(ACT_ALLOC, '0, 11'd0);          // zero count
    send(ACT_ALLOC, '0, 11'd1024);       // whole pool
    send(ACT_ALLOC, '0, 11'd1);          // pool full, no fit
    send(ACT_RELEASE, 20'd1, '0);        // follower, not a head
    send(ACT_RELEASE, 20'd0, '1);        // frees the whole pool
    send(ACT_RELEASE, 20'd1024, '0);     // just past the pool
    send(ACT_RELEASE, 20'hFFFFF, '0);
    send(ACT_MARK, 20'd1020, 11'd8);     // runs off the end
    send(ACT_MARK, 20'd0, 11'd0);        // zero count
    send(ACT_MARK, 20'd10, 11'd5);
    send(ACT_MARK, 20'd12, 11'd3);       // overlaps used frames
    send(ACT_ALLOC, '0, 11'd3);          // first fit at the low end
    send(ACT_ALLOC, '0, 11'd4);
    send(ACT_RELEASE, 20'd12, '0);
    send(ACT_RELEASE, 20'd10, '0);       // stops at the next non-follower
    send(ACT_MARK, 20'd1023, 11'd1);     // last frame of the pool
    send(ACT_RELEASE, 20'd1023, '0);     // stops at the pool end
    send(ACT_NONE, 20'hFFFFF, 11'h7FF);  // unused action code
    send(ACT_ALLOC, '0, 11'd1025);       // larger than the pool

    // Hold off until everything has come back
    drain();

    // Base near the top of the frame space: first_frame wraps
    set_pool(20'hFFFFE, 11'd1024);
    send(ACT_MARK, 20'hFFFFE, 11'd1024);
    send(ACT_RELEASE, 20'hFFFFE, '0);
    send(ACT_MARK, 20'hFFFFE, 11'd2);
    send(ACT_ALLOC, '0, 11'd5);
    repeat (170) random_request();

    set_pool(FNW'($urandom), 11'd1);
    repeat (170) random_request();

    set_pool(FNW'($urandom), 11'd0);     // empty pool
    repeat (60) random_request();

    set_pool(20'd12345, 11'd2047);       // saturates to the store size
    repeat (170) random_request();

    set_pool(FNW'($urandom_range(0, 20'hFFFFF)), CNW'($urandom_range(2, 64)));
    repeat (230) random_request();

    set_pool(20'd0, 11'd1024);
    repeat (110) random_request();
    quiet = 1;
    repeat (120) random_request();

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("contiguous_frame_allocator_core: match");
    else
      $display("contiguous_frame_allocator_core: mismatch");
    $finish;
  end

endmodule

/* contiguous_frame_allocator_core.f */
+incdir+design
design/cfa_pkg.sv
design/cfa_cell.sv
design/contiguous_frame_allocator_core.sv
design/cfa_checker.sv
test/contiguous_frame_allocator_checker.sv
test/contiguous_frame_allocator_core_tb.sv
